// ===== src/fra_pkg.sv =====
`default_nettype none

package fra_pkg;

    localparam int OPND_W    = 32;
    localparam int FUNC_W    = 3;
    localparam int REG_SEL_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD = 3'd0,
        FUNC_ADD  = 3'd1,
        FUNC_MUL  = 3'd2,
        FUNC_DIV  = 3'd3,
        FUNC_REM  = 3'd4,
        FUNC_EQL  = 3'd5
    } t_func;

    // register z sits at this raw index before folding into the file depth
    localparam logic [REG_SEL_W-1:0] Z_SEL = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [REG_SEL_W-1:0] dest_reg;
        logic                 src_is_reg;
        logic [REG_SEL_W-1:0] src_reg;
        logic signed [OPND_W-1:0] operand_value;
    } t_in_item;

    typedef struct packed {
        logic signed [OPND_W-1:0] dest_value;
        logic signed [OPND_W-1:0] z_value;
        logic                     status;
    } t_out_item;

    typedef enum logic [1:0] {
        RSEL_DEST = 2'd0,
        RSEL_SRC  = 2'd1,
        RSEL_Z    = 2'd2
    } t_rsel;

    typedef struct packed {
        logic  latch_in;
        logic  cap_a;
        logic  setup;
        logic  step;
        logic  wr_en;
        logic  cap_z;
        logic  load_out;
        t_rsel rsel;
    } t_dp_cmd;

    typedef struct packed {
        logic needs_iter;
        logic out_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== src/fra_stream_if.sv =====
`default_nettype none

interface fra_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/fra_ram.sv =====
`default_nettype none

module fra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

`default_nettype wire

// ===== src/fra_ctrl.sv =====
`default_nettype none

module fra_ctrl #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire fra_pkg::t_dp_stat  i_stat,
    output fra_pkg::t_dp_cmd        o_cmd
);
    localparam int CNT_W = $clog2(DATA_WIDTH);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RDA   = 8'b0000_0010,
        S_RDB   = 8'b0000_0100,
        S_SETUP = 8'b0000_1000,
        S_RUN   = 8'b0001_0000,
        S_WRITE = 8'b0010_0000,
        S_ZCAP  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '{rsel: fra_pkg::RSEL_DEST, default: 1'b0};
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_RDA;
                end
            end
            S_RDA: begin
                o_cmd.rsel = fra_pkg::RSEL_DEST;
                n_state    = S_RDB;
            end
            S_RDB: begin
                o_cmd.cap_a = 1'b1;
                o_cmd.rsel  = fra_pkg::RSEL_SRC;
                n_state     = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                if (i_stat.needs_iter) begin
                    n_cnt   = CNT_W'(DATA_WIDTH - 1);
                    n_state = S_RUN;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_WRITE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_WRITE: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.rsel  = fra_pkg::RSEL_Z;
                n_state     = S_ZCAP;
            end
            S_ZCAP: begin
                o_cmd.cap_z = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                // hold the finished beat until the output slot frees up
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_accept_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_state == S_RDA)
        else $error("accepted beat did not start the register read");

    a_iter_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SETUP && i_stat.needs_iter
        |=> r_state == S_RUN && r_cnt == CNT_W'(DATA_WIDTH - 1))
        else $error("iteration did not start with a full count");

    a_iter_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN && r_cnt != '0 |=> r_state == S_RUN)
        else $error("iteration left before the count ran out");
endmodule

`default_nettype wire

// ===== src/fra_dpath.sv =====
`default_nettype none

module fra_dpath #(
    parameter int DATA_WIDTH = 32,
    parameter int NUM_REGS   = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fra_pkg::t_in_item  i_item,
    input  wire fra_pkg::t_dp_cmd   i_cmd,
    output fra_pkg::t_dp_stat       o_stat,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output fra_pkg::t_out_item      o_out_item
);
    localparam int W     = DATA_WIDTH;
    localparam int IDX_W = $clog2(NUM_REGS);

    // raw 2-bit selector modulo the file depth; raw stays below twice the depth
    function automatic logic [IDX_W-1:0] fold(input logic [fra_pkg::REG_SEL_W-1:0] raw);
        logic [4:0] v;
        v = {3'b000, raw};
        if (v >= 5'(NUM_REGS)) begin
            v = v - 5'(NUM_REGS);
        end
        return IDX_W'(v);
    endfunction

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? (W'(0) - v) : v;
    endfunction

    localparam logic [IDX_W-1:0] Z_IDX = fold(fra_pkg::Z_SEL);

    logic [fra_pkg::FUNC_W-1:0] r_func;
    logic [IDX_W-1:0]           r_dest, r_src;
    logic                       r_src_is_reg;
    logic [W-1:0]               r_imm, r_a, r_b;
    logic [W-1:0]               r_rem, r_quo, r_opb;
    logic                       r_aneg, r_qneg, r_dz;
    logic [W-1:0]               r_res, r_z;
    logic [NUM_REGS-1:0]        r_vld;
    logic                       r_rd_vld;
    logic                       r_out_vld;
    fra_pkg::t_out_item         r_out_item;

    logic [IDX_W-1:0] rd_addr;
    logic [W-1:0]     ram_rdata, rd_val, b_cur, result;
    logic             is_mul, is_divrem;
    logic [W:0]       div_t, div_diff;
    logic [W-1:0]     mul_sum;

    fra_ram #(
        .WIDTH (W),
        .DEPTH (NUM_REGS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (r_dest),
        .i_wr_data (result),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rdata)
    );

    always_comb begin
        case (i_cmd.rsel)
            fra_pkg::RSEL_DEST: rd_addr = r_dest;
            fra_pkg::RSEL_SRC:  rd_addr = r_src;
            fra_pkg::RSEL_Z:    rd_addr = Z_IDX;
            default:            rd_addr = r_dest;
        endcase
    end

    // entries never written read as the reset value
    assign rd_val    = r_rd_vld ? ram_rdata : '0;
    assign b_cur     = r_src_is_reg ? rd_val : r_imm;
    assign is_mul    = (r_func == fra_pkg::FUNC_MUL);
    assign is_divrem = (r_func == fra_pkg::FUNC_DIV) || (r_func == fra_pkg::FUNC_REM);

    assign o_stat.needs_iter = is_mul || (is_divrem && (b_cur != '0));
    assign o_stat.out_busy   = r_out_vld && !i_out_ready;

    // restoring divide step and shift-add multiply step
    assign div_t    = {r_rem, r_quo[W-1]};
    assign div_diff = div_t - {1'b0, r_opb};
    assign mul_sum  = r_rem + r_opb;

    always_comb begin
        case (r_func)
            fra_pkg::FUNC_LOAD: result = r_imm;
            fra_pkg::FUNC_ADD:  result = r_a + r_b;
            fra_pkg::FUNC_MUL:  result = r_rem;
            fra_pkg::FUNC_DIV:  result = r_dz ? r_a : (r_qneg ? (W'(0) - r_quo) : r_quo);
            fra_pkg::FUNC_REM:  result = r_dz ? r_a : (r_aneg ? (W'(0) - r_rem) : r_rem);
            fra_pkg::FUNC_EQL:  result = (r_a == r_b) ? W'(1) : W'(0);
            default:            result = r_a;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_func       <= i_item.func;
            r_dest       <= fold(i_item.dest_reg);
            r_src        <= fold(i_item.src_reg);
            r_src_is_reg <= i_item.src_is_reg;
            r_imm        <= W'(i_item.operand_value);
        end
        if (i_cmd.cap_a) begin
            r_a <= rd_val;
        end
        if (i_cmd.setup) begin
            r_b    <= b_cur;
            r_aneg <= r_a[W-1];
            r_qneg <= r_a[W-1] ^ b_cur[W-1];
            r_rem  <= '0;
            if (is_mul) begin
                r_quo <= b_cur;
                r_opb <= r_a;
            end else begin
                r_quo <= mag(r_a);
                r_opb <= mag(b_cur);
            end
        end else if (i_cmd.step) begin
            if (is_mul) begin
                if (r_quo[0]) begin
                    r_rem <= mul_sum;
                end
                r_opb <= r_opb << 1;
                r_quo <= r_quo >> 1;
            end else begin
                r_rem <= div_diff[W] ? div_t[W-1:0] : div_diff[W-1:0];
                r_quo <= {r_quo[W-2:0], ~div_diff[W]};
            end
        end
        if (i_cmd.wr_en) begin
            r_res <= result;
        end
        if (i_cmd.cap_z) begin
            r_z <= (Z_IDX == r_dest) ? r_res : rd_val;
        end
        if (i_cmd.load_out) begin
            r_out_item <= '{dest_value: fra_pkg::OPND_W'(r_res),
                            z_value:    fra_pkg::OPND_W'(r_z),
                            status:     r_dz};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_dz      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[rd_addr];
            if (i_cmd.wr_en) begin
                r_vld[r_dest] <= 1'b1;
            end
            if (i_cmd.latch_in) begin
                r_dz <= 1'b0;
            end else if (i_cmd.setup) begin
                r_dz <= is_divrem && (b_cur == '0);
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    a_dz_only_divrem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dz |-> (r_func == fra_pkg::FUNC_DIV || r_func == fra_pkg::FUNC_REM))
        else $error("zero-divisor flag set for a non-divide operation");

    a_write_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |=> r_vld[r_dest])
        else $error("written register not marked valid");
endmodule

`default_nettype wire

// ===== src/four_register_integer_alu_top.sv =====
// Small register-file ALU: each input beat carries one instruction (load, add, multiply,
// signed divide, signed remainder or equal) on a file of NUM_REGS signed DATA_WIDTH-bit
// registers that reset clears to zero, and gives exactly one output beat holding the new
// destination value, register z and a status bit that flags a zero divisor (destination
// then unchanged). Multiply, divide and remainder run on one shared bit-serial unit, one
// bit per cycle; all other instructions and a zero divisor skip the iteration. The single
// read port of the register file issues the destination and source reads one per cycle
// and the z read with the write-back. One instruction is in flight at a time; the next
// is taken as soon as the result has moved into the output register, even if that beat
// is still waiting.
`default_nettype none

module four_register_integer_alu_top #(
    parameter int DATA_WIDTH = 32,
    parameter int NUM_REGS   = 4
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    fra_stream_if.sink    i_in,
    fra_stream_if.source  o_out
);
    fra_pkg::t_dp_cmd  dp_cmd;
    fra_pkg::t_dp_stat dp_stat;
    logic              in_ready;

    fra_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    fra_dpath #(
        .DATA_WIDTH (DATA_WIDTH),
        .NUM_REGS   (NUM_REGS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in.payload),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_item  (o_out.payload)
    );

    assign i_in.ready = in_ready;
endmodule

`default_nettype wire
